// ----- hdl/pqpct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqpct_pkg: shared types for the per-queue port counter table
// operation codes, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package pqpct_pkg;

  // operation codes of an input item (code 3 behaves as a read)
  localparam logic [1:0] OP_PORT     = 2'd0;
  localparam logic [1:0] OP_PORTLESS = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_ISSUE,
    ST_FINISH
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic load;
    logic scan;
    logic issue;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic port_op;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hdl/per_queue_port_counter_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_queue_port_counter_table_core: per-queue destination port statistics
// every receive queue keeps SLOTS port/counter slots and one leftover counter
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid_i/in_ready_o) carries one item: operation, raw
//   queue, destination port and slot; output channel (out_valid_o/out_ready_i)
//   returns exactly one item per input: slot used, its port and its count
// - queue numbers of QUEUES and above all map onto one overflow queue
// - a port item walks the queue's slots one per cycle through the port memory
//   read port, stopping at the matching or first free slot; the counter memory
//   is then read and written back
// - sequence: an accepted item is captured and its queue base loaded; a port
//   item then walks 1..SLOTS slots; the counter memory is read and the result
//   register written; portless and read items skip the walk; the next item is
//   accepted only once the last one has written its result register
// - the result sits in an output register; the next item is accepted while it
//   waits, and only the final update holds until that register is free
// - after reset a clearing sweep zeroes both memories, one counter entry per
//   cycle, with in_ready_o low
// ----------------------------------------------------------------------------
module per_queue_port_counter_table_core #(
  parameter int SLOTS  = 16,
  parameter int QUEUES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] queue_i,
  input  logic [15:0] dest_port_i,
  input  logic [4:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  slot_used_o,
  output logic [15:0] slot_port_o,
  output logic [31:0] slot_count_o
);
  import pqpct_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // state machine: clear sweep, accept, scan, counter read, update
  pqpct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, compare logic, counter increment and result register
  pqpct_dp #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .queue_i      (queue_i),
    .dest_port_i  (dest_port_i),
    .slot_i       (slot_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .slot_used_o  (slot_used_o),
    .slot_port_o  (slot_port_o),
    .slot_count_o (slot_count_o)
  );

endmodule

// ----- hdl/pqpct_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqpct_dp: datapath of the per-queue port counter table
// port and counter memories, slot scan, counter update and result register
// ----------------------------------------------------------------------------
module pqpct_dp #(
  parameter int SLOTS  = 16,
  parameter int QUEUES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pqpct_pkg::dp_cmd_t cmd_i,
  output pqpct_pkg::dp_sts_t sts_o,
  input  logic [1:0]         operation_i,
  input  logic [31:0]        queue_i,
  input  logic [15:0]        dest_port_i,
  input  logic [4:0]         slot_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [4:0]         slot_used_o,
  output logic [15:0]        slot_port_o,
  output logic [31:0]        slot_count_o
);
  import pqpct_pkg::*;

  localparam int BINS   = SLOTS + 1;
  localparam int PDEPTH = (QUEUES + 1) * SLOTS;
  localparam int CDEPTH = (QUEUES + 1) * BINS;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int CAW    = $clog2(CDEPTH);
  localparam int QW     = $clog2(QUEUES + 1);
  localparam int SW     = $clog2(SLOTS + 1);

  logic [15:0] pmem [PDEPTH];
  logic [31:0] cmem [CDEPTH];

  // captured item
  logic [1:0]  op_q;
  logic [QW-1:0] qidx_q;
  logic [15:0] port_q;
  logic [4:0]  sel_q;

  logic [PAW-1:0] pbase_q;
  logic [CAW-1:0] cbase_q;
  logic [SW-1:0]  target_q, rd_idx_q, chk_idx_q;
  logic           claim_q, chk_v_q;
  logic [CAW-1:0] clr_addr_q;
  logic [15:0]    pmem_rd_q;
  logic [31:0]    cmem_rd_q;

  logic           out_valid_q;
  logic [4:0]     slot_used_q;
  logic [15:0]    slot_port_q;
  logic [31:0]    slot_count_q;

  logic [31:0]    sel_ext;
  logic           sel_over, at_leftover, is_count, is_port;
  logic           p_match, p_free, scan_hit, scan_end, rd_more, clr_done;
  logic [SW-1:0]  pidx, load_target;
  logic [PAW-1:0] p_addr, p_waddr;
  logic [CAW-1:0] c_addr, c_waddr;
  logic           p_rd_en, p_we, c_we;
  logic [15:0]    p_wdata, port_res;
  logic [31:0]    c_wdata, count_nxt, count_res;

  assign sel_ext     = 32'(sel_q);
  assign sel_over    = sel_ext >= 32'(SLOTS);
  assign at_leftover = target_q == SW'(SLOTS);
  assign is_port     = op_q == OP_PORT;
  assign is_count    = is_port || (op_q == OP_PORTLESS);
  assign load_target = (op_q == OP_PORTLESS || sel_over) ? SW'(SLOTS) : SW'(sel_ext);

  // scan compare on the entry read in the previous cycle
  assign p_match  = pmem_rd_q == port_q;
  assign p_free   = pmem_rd_q == 16'd0;
  assign scan_hit = chk_v_q && (p_match || p_free);
  assign scan_end = chk_v_q && !scan_hit && (chk_idx_q == SW'(SLOTS - 1));
  assign rd_more  = rd_idx_q < SW'(SLOTS);
  assign clr_done = clr_addr_q == CAW'(CDEPTH - 1);

  assign pidx    = cmd_i.scan ? rd_idx_q : target_q;
  assign p_addr  = pbase_q + PAW'(pidx);
  assign c_addr  = cbase_q + CAW'(target_q);
  assign p_rd_en = (cmd_i.scan && rd_more) || (cmd_i.issue && !at_leftover);

  assign count_nxt = claim_q ? 32'd1 : cmem_rd_q + 32'd1;
  assign count_res = is_count ? count_nxt : cmem_rd_q;

  always_comb begin
    if (at_leftover || op_q == OP_PORTLESS) begin
      port_res = 16'd0;
    end else if (is_port) begin
      port_res = port_q;
    end else begin
      port_res = pmem_rd_q;
    end
  end

  // write port muxes: clearing sweep or the update of a finished item
  assign p_we    = cmd_i.clear ? (clr_addr_q < CAW'(PDEPTH)) : (cmd_i.finish && claim_q);
  assign p_waddr = cmd_i.clear ? PAW'(clr_addr_q) : p_addr;
  assign p_wdata = cmd_i.clear ? 16'd0 : port_q;
  assign c_we    = cmd_i.clear || (cmd_i.finish && is_count);
  assign c_waddr = cmd_i.clear ? clr_addr_q : c_addr;
  assign c_wdata = cmd_i.clear ? 32'd0 : count_nxt;

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    if (p_rd_en) begin
      pmem_rd_q <= pmem[p_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    if (cmd_i.issue) begin
      cmem_rd_q <= cmem[c_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      qidx_q <= (queue_i >= 32'(QUEUES)) ? QW'(QUEUES) : QW'(queue_i);
      port_q <= dest_port_i;
      sel_q  <= slot_i;
    end
    if (cmd_i.load) begin
      pbase_q <= PAW'(qidx_q) * PAW'(SLOTS);
      cbase_q <= CAW'(qidx_q) * CAW'(BINS);
    end
    if (cmd_i.scan) begin
      chk_idx_q <= rd_idx_q;
    end
    if (cmd_i.finish) begin
      slot_used_q  <= 5'(target_q);
      slot_port_q  <= port_res;
      slot_count_q <= count_res;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      rd_idx_q    <= '0;
      chk_v_q     <= 1'b0;
      target_q    <= '0;
      claim_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear && !clr_done) begin
        clr_addr_q <= clr_addr_q + CAW'(1);
      end
      if (cmd_i.load) begin
        rd_idx_q <= '0;
        chk_v_q  <= 1'b0;
        target_q <= load_target;
        claim_q  <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (rd_more) begin
          rd_idx_q <= rd_idx_q + SW'(1);
        end
        chk_v_q <= rd_more;
        if (scan_hit) begin
          target_q <= chk_idx_q;
          claim_q  <= p_free && !p_match;
        end else if (scan_end) begin
          target_q <= SW'(SLOTS);
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_done = clr_done;
  assign sts_o.port_op  = is_port;
  assign sts_o.scan_hit = scan_hit;
  assign sts_o.scan_end = scan_end;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign slot_used_o  = slot_used_q;
  assign slot_port_o  = slot_port_q;
  assign slot_count_o = slot_count_q;

endmodule

// ----- hdl/pqpct_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqpct_ctrl: controller of the per-queue port counter table
// sequences clear sweep, capture, slot scan, counter read and update
// ----------------------------------------------------------------------------
module pqpct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pqpct_pkg::dp_sts_t sts_i,
  output pqpct_pkg::dp_cmd_t cmd_o
);
  import pqpct_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.port_op ? ST_SCAN : ST_ISSUE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_end) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- test/tb_per_queue_port_counter_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_queue_port_counter_table_core: self-checking bench for the port table
// a scoreboard class mirrors the per-queue slot and counter tables, predicts
// the result of every accepted item and checks results in order; stimulus is a
// directed opener followed by random items biased to fill tables, with random
// idling on both channels and one long output stall
// ----------------------------------------------------------------------------
module tb_per_queue_port_counter_table_core;
  import pqpct_pkg::*;

  localparam int SLOTS  = 16;
  localparam int QUEUES = 64;
  localparam int BINS   = SLOTS + 1;

  // code 3 has no name in the package and behaves as a read
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int DIRECTED_ITEMS = 26;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
  localparam int HOLD_AT_ITEM   = 1400;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [4:0]  used;
    logic [15:0] port;
    logic [31:0] count;
  } slot_result_t;

  // mirror of the block: port per slot and counters with leftover bin last
  class port_count_scoreboard;
    bit [15:0]    port_tab [(QUEUES + 1) * SLOTS];
    bit [31:0]    cnt_tab  [(QUEUES + 1) * BINS];
    slot_result_t expected_q [$];
    int           fail_count;

    function new();
      foreach (port_tab[i]) port_tab[i] = '0;
      foreach (cnt_tab[i]) cnt_tab[i] = '0;
      fail_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] q, logic [15:0] port,
                            logic [4:0] slot);
      int           qi;
      int           pbase;
      int           cbase;
      bit           done;
      slot_result_t res;
      qi    = (q >= QUEUES) ? QUEUES : int'(q);
      pbase = qi * SLOTS;
      cbase = qi * BINS;
      done  = 1'b0;
      case (op)
        OP_PORT: begin
          // first slot holding the port, else first free one
          for (int i = 0; i < SLOTS; i++) begin
            if (!done) begin
              if (port_tab[pbase + i] == port) begin
                cnt_tab[cbase + i] = cnt_tab[cbase + i] + 1;
                res  = '{used: 5'(i), port: port_tab[pbase + i],
                         count: cnt_tab[cbase + i]};
                done = 1'b1;
              end else if (port_tab[pbase + i] == 16'd0) begin
                port_tab[pbase + i] = port;
                cnt_tab[cbase + i]  = 32'd1;
                res  = '{used: 5'(i), port: port, count: 32'd1};
                done = 1'b1;
              end
            end
          end
          // full table goes to the leftover bin
          if (!done) begin
            cnt_tab[cbase + SLOTS] = cnt_tab[cbase + SLOTS] + 1;
            res = '{used: 5'(SLOTS), port: 16'd0, count: cnt_tab[cbase + SLOTS]};
          end
        end
        OP_PORTLESS: begin
          cnt_tab[cbase + SLOTS] = cnt_tab[cbase + SLOTS] + 1;
          res = '{used: 5'(SLOTS), port: 16'd0, count: cnt_tab[cbase + SLOTS]};
        end
        default: begin
          if (slot >= SLOTS) begin
            res = '{used: 5'(SLOTS), port: 16'd0, count: cnt_tab[cbase + SLOTS]};
          end else begin
            res = '{used: slot, port: port_tab[pbase + int'(slot)],
                    count: cnt_tab[cbase + int'(slot)]};
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [4:0] used, logic [15:0] port, logic [31:0] count);
      slot_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result: slot_used %0d slot_port %0d slot_count %0d",
               used, port, count);
        fail_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (used !== exp_res.used) begin
        $error("slot_used: expected %0d, actual %0d", exp_res.used, used);
        fail_count++;
      end
      if (port !== exp_res.port) begin
        $error("slot_port: expected %0d, actual %0d", exp_res.port, port);
        fail_count++;
      end
      if (count !== exp_res.count) begin
        $error("slot_count: expected %0d, actual %0d", exp_res.count, count);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  operation   = OP_PORT;
  logic [31:0] queue       = '0;
  logic [15:0] dest_port   = '0;
  logic [4:0]  slot        = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [4:0]  slot_used;
  logic [15:0] slot_port;
  logic [31:0] slot_count;

  port_count_scoreboard sb;

  int          sent_count    = 0;
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 64;
  bit          recv_hold     = 1'b0;

  per_queue_port_counter_table_core #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (operation),
    .queue_i      (queue),
    .dest_port_i  (dest_port),
    .slot_i       (slot),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .slot_used_o  (slot_used),
    .slot_port_o  (slot_port),
    .slot_count_o (slot_count)
  );

  always #5 clk = ~clk;

  // offers one item from a falling edge, returns at the falling edge after accept
  task automatic send_item(input logic [1:0] op, input logic [31:0] q,
                           input logic [15:0] port, input logic [4:0] sl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    queue     <= q;
    dest_port <= port;
    slot      <= sl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, q, port, sl);
    sent_count++;
    // idling phases: sender light / receiver heavy, then swapped, then none
    if (sent_count >= (2 * TOTAL_ITEMS) / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (sent_count >= TOTAL_ITEMS / 3) begin
      send_idle_pct = 64;
      recv_idle_pct = 7;
    end
    @(negedge clk);
  endtask

  // output ready, changed on falling edges only
  always @(negedge clk) begin
    if (recv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(slot_used, slot_port, slot_count);
    end
  end

  // one long output stall so the block backs up into its input
  initial begin
    wait (sent_count >= HOLD_AT_ITEM);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  initial begin
    logic [1:0]  r_op;
    logic [31:0] r_queue;
    logic [15:0] r_port;
    logic [4:0]  r_slot;
    int unsigned pick;

    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // port zero hits the first free slot, which a later port then claims
    send_item(OP_PORT, 32'd0, 16'd0, 5'd0);
    send_item(OP_PORT, 32'd0, 16'd0, 5'd31);
    send_item(OP_PORT, 32'd0, 16'hffff, 5'd0);
    // portless item on the overflow queue, unused fields at their top
    send_item(OP_PORTLESS, 32'hffff_ffff, 16'hffff, 5'd31);
    send_item(OP_READ, 32'd64, 16'd0, 5'd16);
    // read beyond the table and the spare code acting as a read
    send_item(OP_READ, 32'd0, 16'h1234, 5'd31);
    send_item(OP_SPARE, 32'd0, 16'hffff, 5'd0);
    send_item(OP_PORT, 32'd63, 16'h8000, 5'd0);
    // fill one queue, then one more port spills into the leftover bin
    for (int i = 1; i <= SLOTS + 1; i++) begin
      send_item(OP_PORT, 32'd5, 16'(i * 1000), 5'd0);
    end
    send_item(OP_READ, 32'd5, 16'd0, 5'(SLOTS - 1));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 55)      r_op = OP_PORT;
      else if (pick < 70) r_op = OP_PORTLESS;
      else if (pick < 95) r_op = OP_READ;
      else                r_op = OP_SPARE;

      // a few busy queues so tables fill, some spread and some huge indexes
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(5))
          0:       r_queue = 32'd0;
          1:       r_queue = 32'd1;
          2:       r_queue = 32'd2;
          3:       r_queue = 32'd3;
          4:       r_queue = 32'(QUEUES - 1);
          default: r_queue = 32'(QUEUES);
        endcase
      end else if (pick < 85) begin
        r_queue = 32'($urandom_range(QUEUES - 1));
      end else begin
        r_queue = $urandom;
      end

      // small port pool wider than a table, plus zero and full-range ports
      pick = $urandom_range(99);
      if (pick < 70)      r_port = 16'($urandom_range(1, SLOTS + 6));
      else if (pick < 75) r_port = 16'd0;
      else                r_port = 16'($urandom);

      if ($urandom_range(99) < 80) r_slot = 5'($urandom_range(SLOTS));
      else                         r_slot = 5'($urandom_range(31));

      send_item(r_op, r_queue, r_port, r_slot);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
